// ----- rtl/jrct_pkg.sv -----
// ----------------------------------------------------------------------------
// Job ring completion tracker package
// Shared types, codes and sizes for the tracker front, back and top level.
// ----------------------------------------------------------------------------
package jrct_pkg;

  localparam int RING_DEPTH_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam int ADDR_W   = 64;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 32;
  localparam int SLOT_W   = 5;
  localparam int FREE_W   = 6;
  localparam int OC_W     = 2;

  localparam logic FUNC_ENQUEUE  = 1'b0;
  localparam logic FUNC_COMPLETE = 1'b1;

  localparam logic [OC_W-1:0] OC_ENQUEUED = 2'd0;
  localparam logic [OC_W-1:0] OC_FULL     = 2'd1;
  localparam logic [OC_W-1:0] OC_MATCHED  = 2'd2;
  localparam logic [OC_W-1:0] OC_MISSING  = 2'd3;

  typedef struct packed {
    logic                func;
    logic [ADDR_W-1:0]   job_addr;
    logic [TAG_W-1:0]    job_tag;
    logic [STATUS_W-1:0] job_status;
  } in_t;

  typedef struct packed {
    logic [OC_W-1:0]     outcome;
    logic [TAG_W-1:0]    done_tag;
    logic [STATUS_W-1:0] done_status;
    logic [SLOT_W-1:0]   slot;
    logic [FREE_W-1:0]   free_slots;
  } out_t;

  typedef enum logic {
    OP_ENQ,
    OP_DONE
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [ADDR_W-1:0]   addr;
    logic [TAG_W-1:0]    tag;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_SKIP,
    S_EMIT
  } state_t;

endpackage

// ----- rtl/jrct_front.sv -----
// ----------------------------------------------------------------------------
// Tracker front end
// Accepts job beats, decodes the function code and queues the commands.
// ----------------------------------------------------------------------------
module jrct_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_stall,
  input  jrct_pkg::in_t  job,
  output logic           cmd_valid,
  input  logic           cmd_take,
  output jrct_pkg::cmd_t cmd
);

  localparam int PTR_W = $clog2(jrct_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(jrct_pkg::QUEUE_DEPTH + 1);

  jrct_pkg::cmd_t   q [jrct_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  jrct_pkg::cmd_t   decoded;
  logic             push;
  logic             pop;

  always_comb begin
    decoded.addr   = job.job_addr;
    decoded.tag    = job.job_tag;
    decoded.status = job.job_status;
    unique case (job.func)
      jrct_pkg::FUNC_ENQUEUE:  decoded.op = jrct_pkg::OP_ENQ;
      jrct_pkg::FUNC_COMPLETE: decoded.op = jrct_pkg::OP_DONE;
      default:                 decoded.op = jrct_pkg::OP_DONE;
    endcase
  end

  assign job_stall = (count == CNT_W'(jrct_pkg::QUEUE_DEPTH));
  assign push      = job_valid && !job_stall;
  assign cmd_valid = (count != '0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(jrct_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(jrct_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/jrct_back.sv -----
// ----------------------------------------------------------------------------
// Tracker back end
// Holds the ring table, runs enqueues, completion scans and tail skips, and
// drives the registered result beat.
// ----------------------------------------------------------------------------
module jrct_back #(
  parameter int RING_DEPTH = jrct_pkg::RING_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_take,
  input  jrct_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output jrct_pkg::out_t res
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_DEPTH);

  logic [jrct_pkg::ADDR_W-1:0]   addr_mem [RING_DEPTH];
  logic [jrct_pkg::TAG_W-1:0]    tag_mem  [RING_DEPTH];
  logic [jrct_pkg::ADDR_W-1:0]   rd_addr;
  logic [jrct_pkg::TAG_W-1:0]    rd_tag;
  logic [RING_DEPTH-1:0]         valid;
  logic [IDX_W-1:0]              head;
  logic [IDX_W-1:0]              tail;
  logic [CNT_W-1:0]              span;
  logic [IDX_W-1:0]              scan_idx;
  logic [CNT_W-1:0]              scan_cnt;
  logic [jrct_pkg::ADDR_W-1:0]   cur_addr;
  logic [jrct_pkg::STATUS_W-1:0] cur_status;
  jrct_pkg::out_t                pend;
  jrct_pkg::out_t                beat;
  jrct_pkg::state_t              state;
  jrct_pkg::state_t              state_next;

  logic mem_we;
  logic out_load;
  logic hit;
  logic last_scan;
  logic skip_more;
  logic full;

  function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] i);
    nxt = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [jrct_pkg::SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] i);
    logic [31:0] w;
    w       = 32'(i);
    to_slot = w[jrct_pkg::SLOT_W-1:0];
  endfunction

  function automatic logic [jrct_pkg::FREE_W-1:0] to_free(input logic [CNT_W-1:0] s);
    logic [31:0] w;
    w       = 32'(RING_DEPTH) - 32'(s);
    to_free = w[jrct_pkg::FREE_W-1:0];
  endfunction

  assign full      = (span == FULL_CNT);
  assign hit       = valid[scan_idx] && (rd_addr == cur_addr);
  assign last_scan = ((scan_cnt + 1'b1) == span);
  assign skip_more = (span != '0) && !valid[tail];

  always_comb begin
    state_next = state;
    unique case (state)
      jrct_pkg::S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == jrct_pkg::OP_ENQ || span == '0) begin
            state_next = jrct_pkg::S_EMIT;
          end else begin
            state_next = jrct_pkg::S_READ;
          end
        end
      end
      jrct_pkg::S_READ: state_next = jrct_pkg::S_CMP;
      jrct_pkg::S_CMP: begin
        if (hit) begin
          state_next = (scan_idx == tail) ? jrct_pkg::S_SKIP : jrct_pkg::S_EMIT;
        end else if (last_scan) begin
          state_next = jrct_pkg::S_EMIT;
        end else begin
          state_next = jrct_pkg::S_READ;
        end
      end
      jrct_pkg::S_SKIP: begin
        if (!skip_more) begin
          state_next = jrct_pkg::S_EMIT;
        end
      end
      jrct_pkg::S_EMIT: begin
        if (!res_valid || !res_stall) begin
          state_next = jrct_pkg::S_IDLE;
        end
      end
      default: state_next = jrct_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_take = (state == jrct_pkg::S_IDLE) && cmd_valid;
    mem_we   = cmd_take && (cmd.op == jrct_pkg::OP_ENQ) && !full;
    out_load = (state == jrct_pkg::S_EMIT) && (!res_valid || !res_stall);
  end

  always_comb begin
    beat            = pend;
    beat.free_slots = to_free(span);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      addr_mem[head] <= cmd.addr;
      tag_mem[head]  <= cmd.tag;
    end
    rd_addr <= addr_mem[scan_idx];
    rd_tag  <= tag_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jrct_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      head  <= '0;
      tail  <= '0;
      span  <= '0;
    end else begin
      if (mem_we) begin
        valid[head] <= 1'b1;
        head        <= nxt(head);
        span        <= span + 1'b1;
      end else if (state == jrct_pkg::S_CMP && hit) begin
        valid[scan_idx] <= 1'b0;
        if (scan_idx == tail) begin
          tail <= nxt(tail);
          span <= span - 1'b1;
        end
      end else if (state == jrct_pkg::S_SKIP && skip_more) begin
        tail <= nxt(tail);
        span <= span - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur_addr         <= cmd.addr;
      cur_status       <= cmd.status;
      scan_idx         <= tail;
      scan_cnt         <= '0;
      pend.done_tag    <= '0;
      pend.done_status <= '0;
      pend.free_slots  <= '0;
      if (cmd.op == jrct_pkg::OP_ENQ) begin
        pend.outcome <= full ? jrct_pkg::OC_FULL : jrct_pkg::OC_ENQUEUED;
        pend.slot    <= to_slot(head);
      end else begin
        pend.outcome <= jrct_pkg::OC_MISSING;
        pend.slot    <= '0;
      end
    end else if (state == jrct_pkg::S_CMP) begin
      if (hit) begin
        pend.outcome     <= jrct_pkg::OC_MATCHED;
        pend.done_tag    <= rd_tag;
        pend.done_status <= cur_status;
        pend.slot        <= to_slot(scan_idx);
      end else begin
        scan_cnt <= scan_cnt + 1'b1;
        scan_idx <= nxt(scan_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res <= beat;
    end
  end

endmodule

// ----- rtl/job_ring_completion_tracker_core.sv -----
// ----------------------------------------------------------------------------
// Job ring completion tracker
// Ring of in-flight jobs with out-of-order completion matching.
// ----------------------------------------------------------------------------
// Every job beat gives exactly one result beat. A two-entry command queue
// parts the input from the table sequencer, so beats are taken while a result
// waits. An enqueue or a refused enqueue goes straight from idle to emit in
// the sequencer. A completion scans table slots from the tail, with one
// registered read of the address table and one compare per slot (at most
// RING_DEPTH slots); a match at the tail then steps the tail over the cleared
// slots after it. The single read port of the address table sets this pace.
// Reset is immediate: there is no clearing pass.
module job_ring_completion_tracker_core #(
  parameter int RING_DEPTH = jrct_pkg::RING_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_stall,
  input  jrct_pkg::in_t  job,
  output logic           res_valid,
  input  logic           res_stall,
  output jrct_pkg::out_t res
);

  logic           cmd_valid;
  logic           cmd_take;
  jrct_pkg::cmd_t cmd;

  jrct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_stall (job_stall),
    .job       (job),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  jrct_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ----- tb/sv/job_ring_completion_tracker_core_test.sv -----
// ----------------------------------------------------------------------------
// Job ring completion tracker testbench
// Drives enqueue and completion beats into the tracker and predicts each
// result from a ring model of its own. The directed beats cover address and
// tag extremes, duplicate addresses, out-of-order completion, tail skipping
// and misses. A full ring is filled, refused and drained, with the receiver
// holding off at the start. Random rounds then switch at random between
// filling and draining, with random gaps on both sides.
// ----------------------------------------------------------------------------
module job_ring_completion_tracker_core_test;

  localparam int DEPTH       = jrct_pkg::RING_DEPTH_DEF;
  localparam int ITEM_TARGET = 1200;
  localparam int HOLD_LEN    = 400;
  localparam int STUCK_LIMIT = 5000;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           job_valid = 1'b0;
  jrct_pkg::in_t  job       = '0;
  logic           res_stall = 1'b0;
  logic           job_stall;
  logic           res_valid;
  jrct_pkg::out_t res;

  jrct_pkg::in_t  job_q[$];
  jrct_pkg::out_t predicted_q[$];
  logic [63:0]    live_addrs[$];

  int unsigned jobs_queued  = 0;
  int unsigned jobs_taken   = 0;
  int unsigned tx_gap       = 0;
  int unsigned rx_wait      = 0;
  int unsigned hold_left    = 0;
  int unsigned hold_asked   = 0;
  int unsigned hold_granted = 0;
  int unsigned stuck_cycles = 0;
  int unsigned mismatches   = 0;
  bit          tx_idle      = 1'b1;
  bit          rx_idle      = 1'b1;

  // ring model
  logic [63:0] ring_addr[DEPTH];
  logic [15:0] ring_tag[DEPTH];
  bit          ring_live[DEPTH];
  int unsigned ring_head = 0;
  int unsigned ring_tail = 0;
  int unsigned ring_span = 0;

  job_ring_completion_tracker_core #(
    .RING_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .job_valid(job_valid),
    .job_stall(job_stall),
    .job      (job),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  always #5 clk = ~clk;

  function automatic int unsigned next_index(int unsigned i);
    return (i == DEPTH - 1) ? 0 : i + 1;
  endfunction

  function automatic jrct_pkg::out_t track_job(jrct_pkg::in_t j);
    jrct_pkg::out_t r;
    int unsigned    idx;
    bit             found;
    r = '0;
    found = 1'b0;
    if (j.func == jrct_pkg::FUNC_ENQUEUE) begin
      r.slot = jrct_pkg::SLOT_W'(ring_head);
      if (ring_span >= DEPTH) begin
        r.outcome = jrct_pkg::OC_FULL;
      end else begin
        ring_addr[ring_head] = j.job_addr;
        ring_tag[ring_head]  = j.job_tag;
        ring_live[ring_head] = 1'b1;
        ring_head = next_index(ring_head);
        ring_span++;
        r.outcome = jrct_pkg::OC_ENQUEUED;
      end
    end else begin
      r.outcome = jrct_pkg::OC_MISSING;
      idx = ring_tail;
      for (int i = 0; i < ring_span && !found; i++) begin
        if (ring_live[idx] && ring_addr[idx] == j.job_addr) begin
          found = 1'b1;
          ring_live[idx] = 1'b0;
          r.outcome     = jrct_pkg::OC_MATCHED;
          r.done_tag    = ring_tag[idx];
          r.done_status = j.job_status;
          r.slot        = jrct_pkg::SLOT_W'(idx);
          if (idx == ring_tail) begin
            do begin
              ring_tail = next_index(ring_tail);
              ring_span--;
            end while (ring_span > 0 && !ring_live[ring_tail]);
          end
        end
        idx = next_index(idx);
      end
    end
    r.free_slots = jrct_pkg::FREE_W'(DEPTH - ring_span);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand_addr();
    if ($urandom_range(9) < 3) return 64'($urandom_range(7));
    return {$urandom, $urandom};
  endfunction

  task automatic push_job(logic f, logic [63:0] a, logic [15:0] t, logic [31:0] s);
    jrct_pkg::in_t j;
    j.func       = f;
    j.job_addr   = a;
    j.job_tag    = t;
    j.job_status = s;
    job_q.push_back(j);
    jobs_queued++;
  endtask

  task automatic wait_drained();
    while (jobs_taken != jobs_queued || predicted_q.size() != 0) @(posedge clk);
  endtask

  task automatic gen_round(int unsigned n, bit fill);
    int unsigned idx;
    logic [63:0] a;
    for (int k = 0; k < n; k++) begin
      if (live_addrs.size() == 0 || $urandom_range(99) < (fill ? 75 : 25)) begin
        if (live_addrs.size() != 0 && $urandom_range(9) == 0)
          a = live_addrs[$urandom_range(live_addrs.size() - 1)];
        else
          a = rand_addr();
        push_job(jrct_pkg::FUNC_ENQUEUE, a, 16'($urandom), $urandom);
        if (live_addrs.size() < DEPTH) live_addrs.push_back(a);
      end else if ($urandom_range(9) == 0) begin
        push_job(jrct_pkg::FUNC_COMPLETE, rand_addr(), 16'($urandom), $urandom);
      end else begin
        idx = ($urandom_range(2) == 0) ? 0 : $urandom_range(live_addrs.size() - 1);
        a = live_addrs[idx];
        live_addrs.delete(idx);
        push_job(jrct_pkg::FUNC_COMPLETE, a, 16'($urandom), $urandom);
      end
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      tx_gap    <= 0;
    end else begin
      if (job_valid && !job_stall) begin
        predicted_q.push_back(track_job(job));
        jobs_taken++;
      end
      if (!job_valid || !job_stall) begin
        if (tx_gap != 0 || job_q.size() == 0) begin
          job_valid <= 1'b0;
          if (tx_gap != 0) tx_gap <= tx_gap - 1;
        end else begin
          job       <= job_q.pop_front();
          job_valid <= 1'b1;
          tx_gap    <= tx_idle ? pick_gap() : 0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    jrct_pkg::out_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (predicted_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result beat: outcome %0d tag %h status %h slot %0d free %0d",
                     res.outcome, res.done_tag, res.done_status, res.slot, res.free_slots);
          mismatches++;
        end else begin
          want = predicted_q.pop_front();
          if (res.outcome !== want.outcome || res.done_tag !== want.done_tag ||
              res.done_status !== want.done_status || res.slot !== want.slot ||
              res.free_slots !== want.free_slots) begin
            if (mismatches < 10) begin
              $display("mismatch: exp outcome %0d tag %h status %h slot %0d free %0d",
                       want.outcome, want.done_tag, want.done_status, want.slot,
                       want.free_slots);
              $display("          got outcome %0d tag %h status %h slot %0d free %0d",
                       res.outcome, res.done_tag, res.done_status, res.slot,
                       res.free_slots);
            end
            mismatches++;
          end
        end
      end
      if (hold_asked != hold_granted) begin
        hold_granted = hold_asked;
        hold_left    = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (rx_wait != 0) begin
        rx_wait--;
        res_stall <= 1'b1;
      end else begin
        rx_wait = rx_idle ? pick_gap() : 0;
        res_stall <= (rx_wait != 0);
        if (rx_wait != 0) rx_wait--;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((job_valid && !job_stall) || (res_valid && !res_stall))
        stuck_cycles <= 0;
      else
        stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] fill_addrs[$];
    logic [63:0] a;
    int unsigned idx;
    bit          fill;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    push_job(jrct_pkg::FUNC_COMPLETE, 64'h0, 16'h0, 32'hFFFF_FFFF);
    push_job(jrct_pkg::FUNC_ENQUEUE, 64'h0, 16'h0, 32'hFFFF_FFFF);
    push_job(jrct_pkg::FUNC_ENQUEUE, '1, 16'hFFFF, 32'h0);
    push_job(jrct_pkg::FUNC_ENQUEUE, 64'h0000_1000_0000_0040, 16'h0001, 32'h1234_5678);
    push_job(jrct_pkg::FUNC_ENQUEUE, 64'h0000_1000_0000_0040, 16'h0002, 32'h0);
    push_job(jrct_pkg::FUNC_ENQUEUE, 64'h8000_0000_0000_0000, 16'h8000, 32'h0);
    push_job(jrct_pkg::FUNC_COMPLETE, 64'h0000_1000_0000_0040, 16'hFFFF, 32'hA5A5_5A5A);
    push_job(jrct_pkg::FUNC_COMPLETE, 64'h8000_0000_0000_0000, 16'h0, 32'hFFFF_FFFF);
    push_job(jrct_pkg::FUNC_COMPLETE, '1, 16'h0, 32'h8000_0001);
    push_job(jrct_pkg::FUNC_COMPLETE, 64'h0, 16'h0, 32'h0);
    push_job(jrct_pkg::FUNC_COMPLETE, 64'h0000_1000_0000_0040, 16'h0, 32'h0000_0001);
    push_job(jrct_pkg::FUNC_COMPLETE, 64'h0000_1000_0000_0040, 16'h0, 32'h7FFF_FFFF);
    push_job(jrct_pkg::FUNC_COMPLETE, 64'h5555_AAAA_5555_AAAA, 16'hFFFF, 32'hFFFF_FFFF);
    wait_drained();

    // fill past full, with the receiver holding off at first, then drain out of order
    hold_asked++;
    for (int k = 0; k < DEPTH; k++) begin
      a = {$urandom, $urandom};
      fill_addrs.push_back(a);
      push_job(jrct_pkg::FUNC_ENQUEUE, a, 16'($urandom), $urandom);
    end
    push_job(jrct_pkg::FUNC_ENQUEUE, {$urandom, $urandom}, 16'($urandom), $urandom);
    push_job(jrct_pkg::FUNC_ENQUEUE, fill_addrs[0], 16'($urandom), $urandom);
    push_job(jrct_pkg::FUNC_COMPLETE, fill_addrs[DEPTH - 1], 16'($urandom), $urandom);
    fill_addrs.delete(DEPTH - 1);
    while (fill_addrs.size() != 0) begin
      idx = $urandom_range(fill_addrs.size() - 1);
      push_job(jrct_pkg::FUNC_COMPLETE, fill_addrs[idx], 16'($urandom), $urandom);
      fill_addrs.delete(idx);
    end
    wait_drained();

    fill = 1'b1;
    while (jobs_queued < ITEM_TARGET) begin
      tx_idle = ($urandom_range(3) != 0);
      rx_idle = ($urandom_range(3) != 0);
      gen_round($urandom_range(10, 60), fill);
      if ($urandom_range(2) != 0) fill = ~fill;
      if ($urandom_range(4) == 0) begin
        wait_drained();
      end else begin
        while (job_q.size() != 0) @(posedge clk);
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && predicted_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
